// ===== hdl/ciol_pkg.sv =====
// Shared types, constants and the microcode table of the interval owner lookup.
package ciol_pkg;

   localparam int MAX_ENTRIES_DEF = 1024;
   localparam int SCAN_LIMIT_DEF  = 16;

   localparam int TIME_W  = 40;
   localparam int OWNER_W = 17;
   localparam int SLOT_W  = 10;
   localparam int COUNT_W = 11;
   localparam int ENTRY_W = 2 * TIME_W + OWNER_W;

   localparam logic [1:0] MODE_WRITE  = 2'd0;
   localparam logic [1:0] MODE_COMMIT = 2'd1;
   localparam logic [1:0] MODE_LOOKUP = 2'd2;

   localparam logic [OWNER_W-1:0] NO_OWNER = '1;

   // datapath operations
   typedef enum logic [3:0] {
      OP_NONE,
      OP_RD_CACHED,
      OP_TAKE_HIT,
      OP_SCAN_INIT,
      OP_RD_SCAN,
      OP_BS_INIT,
      OP_RD_PROBE,
      OP_BS_STEP,
      OP_RD_LAST,
      OP_MISS,
      OP_FINISH
   } op_type;

   // branch conditions
   typedef enum logic [3:0] {
      C_ALWAYS,
      C_START,
      C_CACHE_OK,
      C_HIT,
      C_SCAN_OK,
      C_SCAN_MORE,
      C_BELOW,
      C_COUNT_NZ,
      C_FIRST_NZ,
      C_OUT_FREE
   } cond_type;

   // microprogram addresses
   typedef enum logic [3:0] {
      U_IDLE,
      U_CACHE_CHK,
      U_CACHE_EVAL,
      U_CACHE_MISS,
      U_SCAN_ISSUE,
      U_SCAN_EVAL,
      U_SCAN_NEXT,
      U_BS_INIT,
      U_BS_ISSUE,
      U_BS_EVAL,
      U_BS_FINAL,
      U_BS_CHECK,
      U_MISS,
      U_DONE
   } upc_type;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      upc_type  on_true;
      upc_type  on_false;
   } uword_type;

   typedef struct packed {
      logic cache_ok;
      logic hit;
      logic scan_ok;
      logic scan_more;
      logic below;
      logic count_nz;
      logic first_nz;
   } dp_flags_type;

   typedef struct packed {
      logic idle;
      logic finish;
   } seq_status_type;

   function automatic uword_type ucode_rom(input upc_type upc);
      uword_type w;
      unique case (upc)
         U_IDLE:       w = '{OP_NONE,      C_START,     U_CACHE_CHK,  U_IDLE};
         U_CACHE_CHK:  w = '{OP_RD_CACHED, C_CACHE_OK,  U_CACHE_EVAL, U_BS_INIT};
         U_CACHE_EVAL: w = '{OP_TAKE_HIT,  C_HIT,       U_DONE,       U_CACHE_MISS};
         U_CACHE_MISS: w = '{OP_SCAN_INIT, C_SCAN_OK,   U_SCAN_ISSUE, U_BS_INIT};
         U_SCAN_ISSUE: w = '{OP_RD_SCAN,   C_SCAN_MORE, U_SCAN_EVAL,  U_BS_INIT};
         U_SCAN_EVAL:  w = '{OP_TAKE_HIT,  C_HIT,       U_DONE,       U_SCAN_NEXT};
         U_SCAN_NEXT:  w = '{OP_NONE,      C_BELOW,     U_BS_INIT,    U_SCAN_ISSUE};
         U_BS_INIT:    w = '{OP_BS_INIT,   C_ALWAYS,    U_BS_ISSUE,   U_BS_ISSUE};
         U_BS_ISSUE:   w = '{OP_RD_PROBE,  C_COUNT_NZ,  U_BS_EVAL,    U_BS_FINAL};
         U_BS_EVAL:    w = '{OP_BS_STEP,   C_ALWAYS,    U_BS_ISSUE,   U_BS_ISSUE};
         U_BS_FINAL:   w = '{OP_RD_LAST,   C_FIRST_NZ,  U_BS_CHECK,   U_MISS};
         U_BS_CHECK:   w = '{OP_TAKE_HIT,  C_HIT,       U_DONE,       U_MISS};
         U_MISS:       w = '{OP_MISS,      C_ALWAYS,    U_DONE,       U_DONE};
         U_DONE:       w = '{OP_FINISH,    C_OUT_FREE,  U_IDLE,       U_DONE};
         default:      w = '{OP_NONE,      C_ALWAYS,    U_IDLE,       U_IDLE};
      endcase
      return w;
   endfunction

endpackage

// ===== hdl/ciol_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module ciol_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/ciol_seq.sv =====
// Microcode sequencer: step counter, control-word table and conditional jumps.
module ciol_seq (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic                     out_free,
   input  ciol_pkg::dp_flags_type   flags,
   output ciol_pkg::uword_type      uword,
   output ciol_pkg::seq_status_type status
);

   ciol_pkg::upc_type   upc_ff;
   ciol_pkg::upc_type   upc_in;
   ciol_pkg::uword_type uw;
   logic                taken;

   assign uw = ciol_pkg::ucode_rom(upc_ff);

   // next step
   always_comb begin
      unique case (uw.cond)
         ciol_pkg::C_ALWAYS:    taken = 1'b1;
         ciol_pkg::C_START:     taken = start;
         ciol_pkg::C_CACHE_OK:  taken = flags.cache_ok;
         ciol_pkg::C_HIT:       taken = flags.hit;
         ciol_pkg::C_SCAN_OK:   taken = flags.scan_ok;
         ciol_pkg::C_SCAN_MORE: taken = flags.scan_more;
         ciol_pkg::C_BELOW:     taken = flags.below;
         ciol_pkg::C_COUNT_NZ:  taken = flags.count_nz;
         ciol_pkg::C_FIRST_NZ:  taken = flags.first_nz;
         ciol_pkg::C_OUT_FREE:  taken = out_free;
         default:               taken = 1'b0;
      endcase
      upc_in = taken ? uw.on_true : uw.on_false;
   end

   // outputs
   always_comb begin
      uword         = uw;
      status.idle   = (upc_ff == ciol_pkg::U_IDLE);
      status.finish = (upc_ff == ciol_pkg::U_DONE) && out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= ciol_pkg::U_IDLE;
      end else begin
         upc_ff <= upc_in;
      end
   end

endmodule

// ===== hdl/ciol_dp.sv =====
// Datapath: interval table, lookup cache, search registers and compares.
module ciol_dp #(
   parameter int MAX_ENTRIES = ciol_pkg::MAX_ENTRIES_DEF,
   parameter int SCAN_LIMIT  = ciol_pkg::SCAN_LIMIT_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_fire,
   input  logic [1:0]                     mode,
   input  logic [ciol_pkg::SLOT_W-1:0]    entry_index,
   input  logic [ciol_pkg::TIME_W-1:0]    start_ms,
   input  logic [ciol_pkg::TIME_W-1:0]    end_ms,
   input  logic [ciol_pkg::OWNER_W-1:0]   owner,
   input  logic [ciol_pkg::COUNT_W-1:0]   entry_count,
   input  logic [ciol_pkg::TIME_W-1:0]    position_ms,
   input  logic                           forward,
   input  ciol_pkg::uword_type            uword,
   output ciol_pkg::dp_flags_type         flags,
   output logic [ciol_pkg::OWNER_W-1:0]   owner_now
);

   localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
   localparam int SC_W  = $clog2(SCAN_LIMIT + 1);
   localparam int TW    = ciol_pkg::TIME_W;

   logic [CNT_W-1:0]            valid_count_ff, valid_count_in;
   logic                        cached_valid_ff, cached_valid_in;
   logic [IDX_W-1:0]            cached_slot_ff, cached_slot_in;
   logic [ciol_pkg::OWNER_W-1:0] cached_owner_ff, cached_owner_in;
   logic                        last_valid_ff, last_valid_in;
   logic [TW-1:0]               last_pos_ff, last_pos_in;
   logic [TW-1:0]               pos_ff, pos_in;
   logic                        fwd_ff, fwd_in;
   logic [IDX_W-1:0]            cur_slot_ff, cur_slot_in;
   logic [CNT_W-1:0]            first_ff, first_in;
   logic [CNT_W-1:0]            count_ff, count_in;
   logic [SC_W-1:0]             scan_cnt_ff, scan_cnt_in;

   logic                        wr_en;
   logic [IDX_W-1:0]            wr_addr;
   logic [ciol_pkg::ENTRY_W-1:0] wr_data;
   logic                        rd_en;
   logic [IDX_W-1:0]            rd_addr;
   logic [ciol_pkg::ENTRY_W-1:0] rd_data;
   logic [TW-1:0]               rd_start;
   logic [TW-1:0]               rd_end;
   logic [ciol_pkg::OWNER_W-1:0] rd_owner;

   logic [CNT_W-1:0]            next_cnt;
   logic [IDX_W-1:0]            next_slot;
   logic [CNT_W-1:0]            half;
   logic [IDX_W-1:0]            probe;
   logic [IDX_W-1:0]            last_slot;

   // entry layout: start in the low bits, then end, then owner
   assign wr_en   = req_fire && (mode == ciol_pkg::MODE_WRITE)
                    && (32'(entry_index) < MAX_ENTRIES);
   assign wr_addr = IDX_W'(entry_index);
   assign wr_data = {owner, end_ms, start_ms};

   ciol_ram #(
      .WIDTH (ciol_pkg::ENTRY_W),
      .DEPTH (MAX_ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_start = rd_data[TW-1:0];
   assign rd_end   = rd_data[2*TW-1:TW];
   assign rd_owner = rd_data[ciol_pkg::ENTRY_W-1:2*TW];

   assign next_cnt  = CNT_W'(cur_slot_ff) + CNT_W'(1);
   assign next_slot = IDX_W'(next_cnt);
   assign half      = count_ff >> 1;
   assign probe     = IDX_W'(first_ff + half);
   assign last_slot = IDX_W'(first_ff - CNT_W'(1));

   always_comb begin
      flags.cache_ok  = cached_valid_ff && (CNT_W'(cached_slot_ff) < valid_count_ff);
      flags.hit       = (pos_ff >= rd_start) && (pos_ff < rd_end);
      flags.scan_ok   = fwd_ff && last_valid_ff && (pos_ff >= last_pos_ff);
      flags.scan_more = (32'(scan_cnt_ff) < SCAN_LIMIT) && (next_cnt < valid_count_ff);
      flags.below     = pos_ff < rd_start;
      flags.count_nz  = (count_ff != '0);
      flags.first_nz  = (first_ff != '0);
   end

   assign owner_now = cached_owner_ff;

   always_comb begin
      valid_count_in  = valid_count_ff;
      cached_valid_in = cached_valid_ff;
      cached_slot_in  = cached_slot_ff;
      cached_owner_in = cached_owner_ff;
      last_valid_in   = last_valid_ff;
      last_pos_in     = last_pos_ff;
      pos_in          = pos_ff;
      fwd_in          = fwd_ff;
      cur_slot_in     = cur_slot_ff;
      first_in        = first_ff;
      count_in        = count_ff;
      scan_cnt_in     = scan_cnt_ff;
      rd_en           = 1'b0;
      rd_addr         = cached_slot_ff;

      // commit: saturate the count, drop the cache
      if (req_fire && (mode == ciol_pkg::MODE_COMMIT)) begin
         if (32'(entry_count) > MAX_ENTRIES) begin
            valid_count_in = CNT_W'(MAX_ENTRIES);
         end else begin
            valid_count_in = CNT_W'(entry_count);
         end
         cached_valid_in = 1'b0;
         cached_slot_in  = '0;
         cached_owner_in = ciol_pkg::NO_OWNER;
         last_valid_in   = 1'b0;
         last_pos_in     = '0;
      end
      if (req_fire && (mode == ciol_pkg::MODE_LOOKUP)) begin
         pos_in = position_ms;
         fwd_in = forward;
      end

      unique case (uword.op)
         ciol_pkg::OP_NONE: begin
         end
         ciol_pkg::OP_RD_CACHED: begin
            rd_en       = 1'b1;
            rd_addr     = cached_slot_ff;
            cur_slot_in = cached_slot_ff;
         end
         ciol_pkg::OP_TAKE_HIT: begin
            if (flags.hit) begin
               cached_valid_in = 1'b1;
               cached_slot_in  = cur_slot_ff;
               cached_owner_in = rd_owner;
            end
         end
         ciol_pkg::OP_SCAN_INIT: begin
            scan_cnt_in = '0;
         end
         ciol_pkg::OP_RD_SCAN: begin
            rd_en       = 1'b1;
            rd_addr     = next_slot;
            cur_slot_in = next_slot;
            scan_cnt_in = scan_cnt_ff + SC_W'(1);
         end
         ciol_pkg::OP_BS_INIT: begin
            first_in = '0;
            count_in = valid_count_ff;
         end
         ciol_pkg::OP_RD_PROBE: begin
            rd_en       = 1'b1;
            rd_addr     = probe;
            cur_slot_in = probe;
         end
         ciol_pkg::OP_BS_STEP: begin
            if (!(pos_ff < rd_start)) begin
               first_in = CNT_W'(cur_slot_ff) + CNT_W'(1);
               count_in = count_ff - half - CNT_W'(1);
            end else begin
               count_in = half;
            end
         end
         ciol_pkg::OP_RD_LAST: begin
            rd_en       = 1'b1;
            rd_addr     = last_slot;
            cur_slot_in = last_slot;
         end
         ciol_pkg::OP_MISS: begin
            cached_valid_in = 1'b0;
            cached_slot_in  = '0;
            cached_owner_in = ciol_pkg::NO_OWNER;
         end
         ciol_pkg::OP_FINISH: begin
            last_valid_in = 1'b1;
            last_pos_in   = pos_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_count_ff  <= '0;
         cached_valid_ff <= 1'b0;
         cached_slot_ff  <= '0;
         cached_owner_ff <= ciol_pkg::NO_OWNER;
         last_valid_ff   <= 1'b0;
         last_pos_ff     <= '0;
      end else begin
         valid_count_ff  <= valid_count_in;
         cached_valid_ff <= cached_valid_in;
         cached_slot_ff  <= cached_slot_in;
         cached_owner_ff <= cached_owner_in;
         last_valid_ff   <= last_valid_in;
         last_pos_ff     <= last_pos_in;
      end
      pos_ff      <= pos_in;
      fwd_ff      <= fwd_in;
      cur_slot_ff <= cur_slot_in;
      first_ff    <= first_in;
      count_ff    <= count_in;
      scan_cnt_ff <= scan_cnt_in;
   end

   // a cached slot always lies inside the committed table
   a_cache_in_range: assert property (@(posedge clock) disable iff (reset)
      cached_valid_ff |-> (CNT_W'(cached_slot_ff) < valid_count_ff))
      else $error("cached slot beyond valid count");

   // the search window never leaves the committed table
   a_search_window: assert property (@(posedge clock) disable iff (reset)
      (uword.op == ciol_pkg::OP_RD_PROBE || uword.op == ciol_pkg::OP_BS_STEP)
      |-> (({1'b0, first_ff} + {1'b0, count_ff}) <= {1'b0, valid_count_ff}))
      else $error("search window beyond valid count");

endmodule

// ===== hdl/cached_interval_owner_lookup_top.sv =====
// Interval owner lookup: a table of time intervals searched by a microcoded sequencer.
//
// Input channel (req_): one beat per command, tuser carries the mode. Mode write loads
// one table slot, mode commit sets the number of valid entries and drops the lookup
// cache, mode lookup asks for the owner of the interval holding position_ms. Write,
// commit and the unused mode give no result.
// Result channel (rsp_): one beat per lookup, the owner found or all ones for none.
// A lookup first checks the cached entry; if that misses, a forward scan may visit the
// entries after it (up to SCAN_LIMIT); failing that, a binary search probes about log2
// of the entry count. The single read port of the table RAM, at most one access per
// microcode step, sets the lookup time; one lookup is in flight at a time.
// The input side takes the next beat while a result waits in the output register; a
// following lookup holds in its last step until that register is free.
// Reset clears the entry count and the cache; table contents are undefined until
// written. A stalled receiver holds the result beat stable.
module cached_interval_owner_lookup_top #(
   parameter int MAX_ENTRIES = ciol_pkg::MAX_ENTRIES_DEF,
   parameter int SCAN_LIMIT  = ciol_pkg::SCAN_LIMIT_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // tdata, from bit 0: entry_index[9:0], start_ms[49:10], end_ms[89:50],
   // owner[106:90], entry_count[117:107], position_ms[157:118], forward[158], zero pad
   input  logic [159:0] req_tdata,
   // tuser, from bit 0: mode[1:0]
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // tdata, from bit 0: owner_found[16:0], zero pad
   output logic [23:0]  rsp_tdata
);

   ciol_pkg::uword_type              uword;
   ciol_pkg::dp_flags_type           flags;
   ciol_pkg::seq_status_type         status;
   logic                             req_fire;
   logic                             start;
   logic                             out_free;
   logic [ciol_pkg::OWNER_W-1:0]     owner_now;
   logic                             rsp_tvalid_ff, rsp_tvalid_in;
   logic [ciol_pkg::OWNER_W-1:0]     rsp_owner_ff, rsp_owner_in;

   // accept a beat only between lookups
   assign req_tready = status.idle;
   assign req_fire   = req_tvalid && req_tready;
   assign start      = req_fire && (req_tuser == ciol_pkg::MODE_LOOKUP);
   // the output register can take a result when empty or draining this cycle
   assign out_free   = !rsp_tvalid_ff || rsp_tready;

   ciol_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .out_free (out_free),
      .flags    (flags),
      .uword    (uword),
      .status   (status)
   );

   ciol_dp #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .SCAN_LIMIT  (SCAN_LIMIT)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_fire    (req_fire),
      .mode        (req_tuser),
      .entry_index (req_tdata[9:0]),
      .start_ms    (req_tdata[49:10]),
      .end_ms      (req_tdata[89:50]),
      .owner       (req_tdata[106:90]),
      .entry_count (req_tdata[117:107]),
      .position_ms (req_tdata[157:118]),
      .forward     (req_tdata[158]),
      .uword       (uword),
      .flags       (flags),
      .owner_now   (owner_now)
   );

   // load the result on the final step, drop it once taken, hold it while stalled
   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_owner_in  = rsp_owner_ff;
      if (status.finish) begin
         rsp_tvalid_in = 1'b1;
         rsp_owner_in  = owner_now;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      rsp_owner_ff <= rsp_owner_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {7'b0, rsp_owner_ff};

   // a lookup closes the input side until its result is produced
   a_lookup_blocks: assert property (@(posedge clock) disable iff (reset)
      start |=> !req_tready)
      else $error("input accepted during a lookup");

endmodule
